### sv/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int OCC_W       = 5;

    localparam logic       OP_ENQ = 1'b0;
    localparam logic       OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] item_data;
        logic signed [PRIO_W-1:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_data;
        logic signed [PRIO_W-1:0] out_priority;
        logic                     out_valid;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### sv/spq_ctrl.sv
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    input  spq_pkg::t_dp_sts i_sts,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/spq_datapath.sv
module spq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    output spq_pkg::t_dp_sts   o_sts,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    t_in_item                 r_in;
    logic signed [DATA_W-1:0] r_data [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] r_prio [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] n_data [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] n_prio [QUEUE_DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_full;
    t_out_item                r_out;
    t_out_item                n_out;
    logic [QUEUE_DEPTH-1:0]   w_ge;
    logic                     w_full;
    logic                     w_empty;

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    // Each slot compares itself against the new priority; the sorted order
    // makes the set of slots that stay in place a prefix.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) < r_count) && (r_prio[i] >= r_in.item_priority);
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_data[i] = r_data[i];
            n_prio[i] = r_prio[i];
        end
        if (r_in.op == OP_ENQ) begin
            if (w_full) begin
                n_out.status = ST_OVERFLOW;
            end else begin
                n_out.status = ST_OK;
                n_count      = r_count + 1'b1;
                if (!w_ge[0]) begin
                    n_data[0] = r_in.item_data;
                    n_prio[0] = r_in.item_priority;
                end
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    if (!w_ge[i]) begin
                        if (w_ge[i-1]) begin
                            n_data[i] = r_in.item_data;
                            n_prio[i] = r_in.item_priority;
                        end else begin
                            n_data[i] = r_data[i-1];
                            n_prio[i] = r_prio[i-1];
                        end
                    end
                end
            end
        end else begin
            if (w_empty) begin
                n_out.status = ST_UNDERFLOW;
            end else begin
                n_out.status       = ST_OK;
                n_out.out_valid    = 1'b1;
                n_out.out_data     = r_data[0];
                n_out.out_priority = r_prio[0];
                n_count            = r_count - 1'b1;
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    n_data[i] = r_data[i+1];
                    n_prio[i] = r_prio[i+1];
                end
            end
        end
        n_out.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_data[i] <= n_data[i];
                r_prio[i] <= n_prio[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_out_full <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count    <= n_count;
                r_out_full <= 1'b1;
            end else if (i_out_ready) begin
                r_out_full <= 1'b0;
            end
        end
    end

    assign o_sts.out_full = r_out_full;
    assign o_out_valid    = r_out_full;
    assign o_out_item     = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds depth");

    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_full)
        else $error("executed step did not present a result");

    a_no_exec_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_out_full) |-> i_out_ready)
        else $error("result overwritten before transfer");

    a_deq_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && r_out.out_valid) |-> (r_out.status == ST_OK))
        else $error("returned entry with error status");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_in.op == OP_ENQ) && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow the queue");

endmodule

### sv/stable_priority_queue.sv
// Items are registered in r_in; results in r_out during S_EXEC, once the output is free.
// New items are taken only in S_IDLE, so none is taken until S_EXEC ends; the slot
// row compares all entries in parallel and shifts or inserts in one step.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// slot contents are not cleared and no clearing pass is needed.
module stable_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
    int        held_count = 0;
    t_out_item pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;
    int cycle_count = 0;
    int error_count = 0;
    int sent_count = 0;
    int result_count = 0;
    int underflow_count = 0;
    int overflow_count = 0;
    int full_count = 0;

    stable_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Keeps the expected queue contents sorted, highest priority first, and
    // places a new entry behind every entry of equal or higher priority.
    function automatic t_out_item queue_model_step(t_in_item it);
        t_out_item res;
        int pos;
        res = '0;
        res.status = ST_OK;
        if (it.op == OP_ENQ) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = ST_OVERFLOW;
                overflow_count++;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] >= it.item_priority) pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = it.item_data;
                held_prio[pos] = it.item_priority;
                held_count++;
                if (held_count == QUEUE_DEPTH) begin
                    full_count++;
                end
            end
        end else if (held_count == 0) begin
            res.status = ST_UNDERFLOW;
            underflow_count++;
        end else begin
            res.out_data = held_data[0];
            res.out_priority = held_prio[0];
            res.out_valid = 1'b1;
            for (int i = 0; i + 1 < held_count; i++) begin
                held_data[i] = held_data[i+1];
                held_prio[i] = held_prio[i+1];
            end
            held_count--;
        end
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    function automatic t_in_item make_item(logic op, logic [DATA_W-1:0] dat,
                                           logic [PRIO_W-1:0] pri);
        t_in_item it;
        it.op = op;
        it.item_data = dat;
        it.item_priority = pri;
        return it;
    endfunction

    function automatic t_in_item random_item(int enq_pct);
        t_in_item it;
        it.op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        it.item_data = $urandom();
        case ($urandom_range(3))
            0: it.item_priority = PRIO_W'(int'($urandom_range(4)) - 2);
            1: it.item_priority = PRIO_W'($urandom());
            2: it.item_priority = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
            default: it.item_priority = PRIO_W'($urandom_range(7));
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(queue_model_step(it));
        sent_count++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic test_directed_corners();
        send_item(make_item(OP_DEQ, '0, '0));
        send_item(make_item(OP_ENQ, 32'h7fff_ffff, 16'h7fff));
        send_item(make_item(OP_ENQ, 32'h8000_0000, 16'h8000));
        send_item(make_item(OP_ENQ, 32'h0000_0000, 16'h0000));
        send_item(make_item(OP_ENQ, 32'h0000_0001, 16'h0000));
        send_item(make_item(OP_ENQ, 32'hffff_ffff, 16'hffff));
        send_item(make_item(OP_ENQ, 32'h0000_0002, 16'h7fff));
        send_item(make_item(OP_ENQ, 32'h0000_0003, 16'h0000));
        for (int k = 0; k < 9; k++) begin
            send_item(make_item(OP_ENQ, 32'ha5a5_0000 + k, PRIO_W'(k * 4096 - 16384)));
        end
        send_item(make_item(OP_ENQ, 32'hdead_beef, 16'h7fff));
        repeat (5) send_item(make_item(OP_DEQ, 32'hffff_ffff, 16'hffff));
    endtask

    // Each burst leans toward enqueues or dequeues or is balanced, so the queue swings between
    // full and empty.
    task automatic test_random_traffic(input int n_items);
        int enq_pct;
        enq_pct = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 20 == 0) begin
                enq_pct = 10 + 40 * int'($urandom_range(2));
            end
            send_item(random_item(enq_pct));
        end
    endtask

    task automatic test_backpressure_fill();
        int saved_idle;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        recv_hold = 80;
        repeat (40) send_item(random_item(75));
        send_idle_pct = saved_idle;
    endtask

    task automatic test_drain_pause();
        wait_results_drained();
        repeat (20) send_item(random_item(50));
    endtask

    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("out_data", want.out_data, o_out_item.out_data);
                check_field("out_priority", DATA_W'(want.out_priority),
                            DATA_W'(o_out_item.out_priority));
                check_field("out_valid", DATA_W'(want.out_valid),
                            DATA_W'(o_out_item.out_valid));
                check_field("status", DATA_W'(want.status), DATA_W'(o_out_item.status));
                check_field("occupancy", DATA_W'(want.occupancy),
                            DATA_W'(o_out_item.occupancy));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        send_idle_pct = 30;
        recv_idle_pct = 57;
        test_random_traffic(110);
        send_idle_pct = 57;
        recv_idle_pct = 30;
        test_random_traffic(110);
        test_backpressure_fill();
        test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d transfers and checked %0d results in %0d cycles.",
                 sent_count, result_count, cycle_count);
        $display("Saw %0d underflows, %0d overflows and reached a full queue %0d times.",
                 underflow_count, overflow_count, full_count);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
